// ===== hdl/mf3_pkg.sv =====
// ----------------------------------------------------------------------------
// mf3_pkg
// Shared types, constants and small compare helpers for the 3x3 median core.
// ----------------------------------------------------------------------------
`default_nettype none

package mf3_pkg;

	// Pixel and configuration widths
	localparam int PIX_W      = 8;
	localparam int CFG_W      = 11;
	localparam int CFG_IDX_W  = 1;

	// Default frame limits handed to the top level
	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 1024;
	localparam int MIN_SIZE       = 3;

	// Register reset values
	localparam logic [CFG_W-1:0] WIDTH_RST  = 11'd640;
	localparam logic [CFG_W-1:0] HEIGHT_RST = 11'd480;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} cfg_reg_t;

	// One window column, sorted low to high
	typedef struct packed {
		logic [PIX_W-1:0] hi;
		logic [PIX_W-1:0] md;
		logic [PIX_W-1:0] lo;
	} col_t;

	function automatic logic [PIX_W-1:0] min2(input logic [PIX_W-1:0] a,
			input logic [PIX_W-1:0] b);
		return (a < b) ? a : b;
	endfunction

	function automatic logic [PIX_W-1:0] max2(input logic [PIX_W-1:0] a,
			input logic [PIX_W-1:0] b);
		return (a < b) ? b : a;
	endfunction

	// Middle of three: max(min(a,b), min(max(a,b), c))
	function automatic logic [PIX_W-1:0] med3(input logic [PIX_W-1:0] a,
			input logic [PIX_W-1:0] b, input logic [PIX_W-1:0] c);
		return max2(min2(a, b), min2(max2(a, b), c));
	endfunction

	// Sort three pixels into a column
	function automatic col_t sort3(input logic [PIX_W-1:0] a,
			input logic [PIX_W-1:0] b, input logic [PIX_W-1:0] c);
		col_t col;
		col.lo = min2(min2(a, b), c);
		col.hi = max2(max2(a, b), c);
		col.md = med3(a, b, c);
		return col;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/mf3_line_ram.sv =====
// ----------------------------------------------------------------------------
// mf3_line_ram
// Simple dual-port line store: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module mf3_line_ram #(
	parameter int DEPTH  = 1024,
	parameter int DATA_W = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [DATA_W-1:0]        wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [DATA_W-1:0]        rd_data
);

	logic [DATA_W-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Read port, data held until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== hdl/mf3_median.sv =====
// ----------------------------------------------------------------------------
// mf3_median
// Median of a 3x3 window built from three pre-sorted columns.
// ----------------------------------------------------------------------------
`default_nettype none

module mf3_median (
	input  wire mf3_pkg::col_t                  col0,
	input  wire mf3_pkg::col_t                  col1,
	input  wire mf3_pkg::col_t                  col2,
	output logic      [mf3_pkg::PIX_W-1:0]      med
);

	logic [mf3_pkg::PIX_W-1:0] max_lo;
	logic [mf3_pkg::PIX_W-1:0] med_md;
	logic [mf3_pkg::PIX_W-1:0] min_hi;

	// Largest of the column minima, middle of the medians, smallest of the maxima
	always_comb begin
		max_lo = mf3_pkg::max2(mf3_pkg::max2(col0.lo, col1.lo), col2.lo);
		med_md = mf3_pkg::med3(col0.md, col1.md, col2.md);
		min_hi = mf3_pkg::min2(mf3_pkg::min2(col0.hi, col1.hi), col2.hi);
		med    = mf3_pkg::med3(max_lo, med_md, min_hi);
	end

endmodule

`default_nettype wire

// ===== hdl/median_filter_3x3_core.sv =====
// ----------------------------------------------------------------------------
// median_filter_3x3_core
// Streaming 3x3 median over a raster-order grey frame; interior pixels only.
// ----------------------------------------------------------------------------
//
//  channel   | direction | payload                               | handshake
//  ----------+-----------+---------------------------------------+-----------------
//  s_axis    | in        | tdata[7:0] pixel_in                   | tvalid/tready
//  m_axis    | out       | tdata[7:0] pixel_out, tlast frame_last| tvalid/tready
//  cfg       | in        | cfg_index, cfg_data[10:0]             | cfg_valid/ready
//
//  One pixel per clock sustained while results are taken; the first step reads
//  the line store (registered read port) as the pixel is registered; the next
//  sorts the new column, takes the median and loads the output register.
//  A stalled output holds the output register; the input stage keeps taking
//  beats while the held result waits, and stops only when both are full.
//  Reset clears counters, window and valid flags; line stores are not cleared.
//
`default_nettype none

module median_filter_3x3_core #(
	parameter int MAX_WIDTH  = mf3_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = mf3_pkg::MAX_HEIGHT_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// Pixel input
	input  wire logic                          s_axis_tvalid,
	output logic                               s_axis_tready,
	input  wire logic [mf3_pkg::PIX_W-1:0]     s_axis_tdata,   // [7:0] pixel_in
	// Result output
	output logic                               m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	output logic      [mf3_pkg::PIX_W-1:0]     m_axis_tdata,   // [7:0] pixel_out
	output logic                               m_axis_tlast,   // frame_last
	// Configuration writes
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [mf3_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [mf3_pkg::CFG_W-1:0]     cfg_data
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int SW = WW + 1;
	localparam int TW = HW + 1;
	localparam int PW = mf3_pkg::PIX_W;

	// Configuration registers
	logic [mf3_pkg::CFG_W-1:0] width_q;
	logic [mf3_pkg::CFG_W-1:0] height_q;

	// Position of the next pixel
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;

	// Input stage
	logic          valid_s1;
	logic [PW-1:0] px_s1;
	logic [CW-1:0] addr_s1;
	logic          emit_s1;
	logic          last_s1;

	// Window of the two previous sorted columns
	mf3_pkg::col_t win0_q;
	mf3_pkg::col_t win1_q;

	// Output register
	logic          out_valid_q;
	logic [PW-1:0] out_pix_q;
	logic          out_last_q;

	logic [WW-1:0]   w_eff;
	logic [HW-1:0]   h_eff;
	logic            last_col;
	logic            last_row;
	logic            in_acc;
	logic            adv_s1;
	logic [2*PW-1:0] rd_word;
	logic [PW-1:0]   up_s1;
	logic [PW-1:0]   mid_s1;
	mf3_pkg::col_t   new_col;
	logic [PW-1:0]   med;

	// Configuration port always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= mf3_pkg::WIDTH_RST;
			height_q <= mf3_pkg::HEIGHT_RST;
		end else if (cfg_valid) begin
			unique case (mf3_pkg::cfg_reg_t'(cfg_index))
				mf3_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_data;
				mf3_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Clamp frame size to the supported range
	always_comb begin
		if (width_q < mf3_pkg::CFG_W'(mf3_pkg::MIN_SIZE)) begin
			w_eff = WW'(mf3_pkg::MIN_SIZE);
		end else if (int'(width_q) > MAX_WIDTH) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(width_q);
		end
		if (height_q < mf3_pkg::CFG_W'(mf3_pkg::MIN_SIZE)) begin
			h_eff = HW'(mf3_pkg::MIN_SIZE);
		end else if (int'(height_q) > MAX_HEIGHT) begin
			h_eff = HW'(MAX_HEIGHT);
		end else begin
			h_eff = HW'(height_q);
		end
	end

	assign last_col = (SW'(col_q) + SW'(1)) >= SW'(w_eff);
	assign last_row = (TW'(row_q) + TW'(1)) >= TW'(h_eff);

	// Handshake: stage 1 moves on unless it holds a result and the output is full
	assign adv_s1        = valid_s1 && (!emit_s1 || !out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv_s1;
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	// Advance the raster position on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_acc) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// Input stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	// Input stage payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			px_s1   <= s_axis_tdata;
			addr_s1 <= col_q;
			emit_s1 <= (row_q >= RW'(2)) && (col_q >= CW'(2));
			last_s1 <= last_col && last_row;
		end
	end

	// Line stores: upper row in the high byte, middle row in the low byte
	mf3_line_ram #(
		.DEPTH  (MAX_WIDTH),
		.DATA_W (2 * PW)
	) u_line_ram (
		.clk     (clk),
		.wr_en   (adv_s1),
		.wr_addr (addr_s1),
		.wr_data ({mid_s1, px_s1}),
		.rd_en   (in_acc),
		.rd_addr (col_q),
		.rd_data (rd_word)
	);

	assign up_s1  = rd_word[2*PW-1:PW];
	assign mid_s1 = rd_word[PW-1:0];

	// Sort the incoming column
	assign new_col = mf3_pkg::sort3(up_s1, mid_s1, px_s1);

	mf3_median u_median (
		.col0 (win0_q),
		.col1 (win1_q),
		.col2 (new_col),
		.med  (med)
	);

	// Shift the window by one column
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win0_q <= '0;
			win1_q <= '0;
		end else if (adv_s1) begin
			win0_q <= win1_q;
			win1_q <= new_col;
		end
	end

	// Output valid: load on an emitting advance, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && emit_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && emit_s1) begin
			out_pix_q  <= med;
			out_last_q <= last_s1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_pix_q;
	assign m_axis_tlast  = out_last_q;

	// Input may stall only while stage 1 is occupied
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> valid_s1)
		else $error("input stalled with empty stage 1");

	// A beat that produces no result never waits in stage 1
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !emit_s1) |-> adv_s1)
		else $error("non-emitting beat held in stage 1");

	// An emitting advance always shows a result next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && emit_s1) |=> m_axis_tvalid)
		else $error("emitted result lost");

endmodule

`default_nettype wire
